### rtl/core/todtc_pkg.sv
// ----------------------------------------------------------------------------
// todtc_pkg
// Shared types and constants of the time-of-day tick counter.
// ----------------------------------------------------------------------------
package todtc_pkg;

   typedef enum logic [1:0] {
      OP_TICK     = 2'd0,
      OP_SET_SEC  = 2'd1,
      OP_SET_MIN  = 2'd2,
      OP_SET_HOUR = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      CSR_TICK_PERIOD = 2'd0,
      CSR_MS_WRAP     = 2'd1,
      CSR_HOUR_MOD    = 2'd2
   } csr_index_type;

   localparam int unsigned CSR_DATA_W = 16;

   localparam logic [9:0]  TICK_PERIOD_RESET = 10'd32;
   localparam logic [15:0] MS_WRAP_RESET     = 16'd60000;
   localparam logic [4:0]  HOUR_MOD_RESET    = 5'd24;

   localparam logic [9:0]  MAX_PERIOD_US  = 10'd1000;
   localparam logic [19:0] US_PER_SECOND  = 20'd1000000;
   localparam logic [10:0] US_PER_MILLI   = 11'd1000;
   localparam logic [6:0]  SEC_MIN_MOD    = 7'd60;
   localparam logic [7:0]  MAX_SEC_MIN    = 8'd59;
   localparam logic [7:0]  MAX_HOUR_SET   = 8'd23;

   typedef struct packed {
      logic [9:0]  tick_period_us;
      logic [15:0] ms_wrap;
      logic [4:0]  hour_mod;
   } config_type;

   typedef struct packed {
      logic [19:0] second_accum_us;
      logic [10:0] milli_accum_us;
      logic [5:0]  sec;
      logic [5:0]  min;
      logic [4:0]  hour;
      logic [15:0] ms;
   } time_state_type;

endpackage

### rtl/core/todtc_req_if.sv
// ----------------------------------------------------------------------------
// todtc_req_if
// Request channel: tick and set items with valid/ready handshake.
// ----------------------------------------------------------------------------
interface todtc_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [7:0] set_value;

   modport source (output valid, output opcode, output set_value, input ready);
   modport sink   (input valid, input opcode, input set_value, output ready);
endinterface

### rtl/core/todtc_rsp_if.sv
// ----------------------------------------------------------------------------
// todtc_rsp_if
// Response channel: current time and millisecond count per item.
// ----------------------------------------------------------------------------
interface todtc_rsp_if;
   logic        valid;
   logic        ready;
   logic [5:0]  seconds;
   logic [5:0]  minutes;
   logic [4:0]  hours;
   logic [15:0] ms_count;

   modport source (output valid, output seconds, output minutes, output hours,
                   output ms_count, input ready);
   modport sink   (input valid, input seconds, input minutes, input hours,
                   input ms_count, output ready);
endinterface

### rtl/core/todtc_update.sv
// ----------------------------------------------------------------------------
// todtc_update
// Next-state logic: accumulate tick period, cascade s/m/h, ms counter, sets.
// ----------------------------------------------------------------------------
module todtc_update (
   input  todtc_pkg::time_state_type state,
   input  todtc_pkg::config_type     cfg,
   input  logic [1:0]                opcode,
   input  logic [7:0]                set_value,
   output todtc_pkg::time_state_type state_next
);

   logic [9:0]  period;
   logic [19:0] sec_sum;
   logic [10:0] milli_sum;
   logic        sec_roll;
   logic        milli_roll;
   logic [6:0]  sec_inc;
   logic [6:0]  min_inc;
   logic [5:0]  hour_inc;
   logic [16:0] ms_inc;
   logic [5:0]  sec_adv;
   logic [5:0]  min_adv;
   logic [4:0]  hour_adv;
   logic [15:0] ms_adv;
   logic [7:0]  sec_min_set;
   logic [7:0]  hour_set;

   always_comb begin
      period    = (cfg.tick_period_us > todtc_pkg::MAX_PERIOD_US) ?
                  todtc_pkg::MAX_PERIOD_US : cfg.tick_period_us;
      sec_sum   = state.second_accum_us + {10'd0, period};
      milli_sum = state.milli_accum_us + {1'b0, period};
      sec_roll   = (sec_sum >= todtc_pkg::US_PER_SECOND);
      milli_roll = (milli_sum >= todtc_pkg::US_PER_MILLI);

      sec_inc  = {1'b0, state.sec} + 7'd1;
      min_inc  = {1'b0, state.min} + 7'd1;
      hour_inc = {1'b0, state.hour} + 6'd1;
      ms_inc   = {1'b0, state.ms} + 17'd1;
      sec_adv  = (sec_inc >= todtc_pkg::SEC_MIN_MOD) ? 6'd0 : sec_inc[5:0];
      min_adv  = (min_inc >= todtc_pkg::SEC_MIN_MOD) ? 6'd0 : min_inc[5:0];
      hour_adv = (hour_inc >= {1'b0, cfg.hour_mod}) ? 5'd0 : hour_inc[4:0];
      ms_adv   = (ms_inc >= {1'b0, cfg.ms_wrap}) ? 16'd0 : ms_inc[15:0];

      sec_min_set = (set_value > todtc_pkg::MAX_SEC_MIN) ?
                    todtc_pkg::MAX_SEC_MIN : set_value;
      hour_set    = (set_value > todtc_pkg::MAX_HOUR_SET) ?
                    todtc_pkg::MAX_HOUR_SET : set_value;

      state_next = state;
      case (todtc_pkg::opcode_type'(opcode))
         todtc_pkg::OP_TICK: begin
            if (sec_roll) begin
               state_next.second_accum_us = sec_sum - todtc_pkg::US_PER_SECOND;
               state_next.sec = sec_adv;
               if (sec_adv == 6'd0) begin
                  state_next.min = min_adv;
                  if (min_adv == 6'd0) begin
                     state_next.hour = hour_adv;
                  end
               end
            end else begin
               state_next.second_accum_us = sec_sum;
            end
            if (milli_roll) begin
               state_next.milli_accum_us = milli_sum - todtc_pkg::US_PER_MILLI;
               state_next.ms = ms_adv;
            end else begin
               state_next.milli_accum_us = milli_sum;
            end
         end
         todtc_pkg::OP_SET_SEC: begin
            state_next.sec = sec_min_set[5:0];
         end
         todtc_pkg::OP_SET_MIN: begin
            state_next.min = sec_min_set[5:0];
         end
         todtc_pkg::OP_SET_HOUR: begin
            state_next.hour = hour_set[4:0];
         end
         default: begin
            state_next = state;
         end
      endcase
   end

endmodule

### rtl/core/time_of_day_tick_counter_core.sv
// ----------------------------------------------------------------------------
// time_of_day_tick_counter_core
// Hours/minutes/seconds clock and millisecond counter driven by tick items.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  req     | in  | valid/ready        | opcode, set_value
//  rsp     | out | valid/ready        | seconds, minutes, hours, ms_count
//  csr     | in  | csr_write_enable   | csr_index, csr_write_data
//
//  One item per cycle while the response is not stalled; the result passes
//  through the input register, update logic and result register.
//  Synchronous reset clears time state and loads register defaults.
//  A stalled result holds; the input register still takes one more item.
// ----------------------------------------------------------------------------
module time_of_day_tick_counter_core (
   input  logic        clock,
   input  logic        reset,
   todtc_req_if.sink   req,
   todtc_rsp_if.source rsp,
   input  logic                            csr_write_enable,
   input  logic [1:0]                      csr_index,
   input  logic [todtc_pkg::CSR_DATA_W-1:0] csr_write_data
);

   todtc_pkg::config_type     cfg_ff;
   todtc_pkg::time_state_type state_ff;
   todtc_pkg::time_state_type state_in;

   logic       s1_valid_ff;
   logic [1:0] s1_opcode_ff;
   logic [7:0] s1_value_ff;

   logic        out_valid_ff;
   logic [5:0]  out_sec_ff;
   logic [5:0]  out_min_ff;
   logic [4:0]  out_hour_ff;
   logic [15:0] out_ms_ff;

   logic advance;
   logic s1_fire;

   assign advance   = !out_valid_ff || rsp.ready;
   assign s1_fire   = s1_valid_ff && advance;
   assign req.ready = !s1_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tick_period_us <= todtc_pkg::TICK_PERIOD_RESET;
         cfg_ff.ms_wrap        <= todtc_pkg::MS_WRAP_RESET;
         cfg_ff.hour_mod       <= todtc_pkg::HOUR_MOD_RESET;
      end else if (csr_write_enable) begin
         case (todtc_pkg::csr_index_type'(csr_index))
            todtc_pkg::CSR_TICK_PERIOD: cfg_ff.tick_period_us <= csr_write_data[9:0];
            todtc_pkg::CSR_MS_WRAP:     cfg_ff.ms_wrap        <= csr_write_data[15:0];
            todtc_pkg::CSR_HOUR_MOD:    cfg_ff.hour_mod       <= csr_write_data[4:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req.ready) begin
         s1_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.ready && req.valid) begin
         s1_opcode_ff <= req.opcode;
         s1_value_ff  <= req.set_value;
      end
   end

   todtc_update u_update (
      .state      (state_ff),
      .cfg        (cfg_ff),
      .opcode     (s1_opcode_ff),
      .set_value  (s1_value_ff),
      .state_next (state_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (s1_fire) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         out_sec_ff  <= state_in.sec;
         out_min_ff  <= state_in.min;
         out_hour_ff <= state_in.hour;
         out_ms_ff   <= state_in.ms;
      end
   end

   assign rsp.valid    = out_valid_ff;
   assign rsp.seconds  = out_sec_ff;
   assign rsp.minutes  = out_min_ff;
   assign rsp.hours    = out_hour_ff;
   assign rsp.ms_count = out_ms_ff;

endmodule

### rtl/core/todtc_checker.sv
// ----------------------------------------------------------------------------
// todtc_checker
// Port-level assertions for the time-of-day tick counter, bound to the core.
// ----------------------------------------------------------------------------
module todtc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [5:0]  rsp_seconds,
   input logic [5:0]  rsp_minutes,
   input logic [4:0]  rsp_hours,
   input logic [15:0] rsp_ms_count
);

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_seconds) && $stable(rsp_minutes)
         && $stable(rsp_hours) && $stable(rsp_ms_count))
      else $error("rsp payload changed while stalled");

   a_sec_min_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_seconds < 6'd60) && (rsp_minutes < 6'd60))
      else $error("seconds or minutes out of range");

endmodule

bind time_of_day_tick_counter_core todtc_checker u_todtc_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp.valid),
   .rsp_ready    (rsp.ready),
   .rsp_seconds  (rsp.seconds),
   .rsp_minutes  (rsp.minutes),
   .rsp_hours    (rsp.hours),
   .rsp_ms_count (rsp.ms_count)
);
